>>> rtl/qvr_pkg.sv
`default_nettype none

package qvr_pkg;

    typedef struct packed {
        logic valid;
        logic zero;
    } qvr_ctl_t;

    localparam int LANES = 3;

endpackage

`default_nettype wire

>>> rtl/qvr_if.sv
`default_nettype none

interface qvr_in_if #(
    parameter int QW = 16,
    parameter int VW = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic signed [QW-1:0] quat_w;
    logic signed [VW-1:0] vec_x;
    logic signed [VW-1:0] vec_y;
    logic signed [VW-1:0] vec_z;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
        input  ready
    );

    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
        output ready
    );
endinterface

interface qvr_out_if #(
    parameter int VW = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] rot_x;
    logic signed [VW-1:0] rot_y;
    logic signed [VW-1:0] rot_z;
    logic                 clipped;

    modport source (
        output valid, rot_x, rot_y, rot_z, clipped,
        input  ready
    );

    modport sink (
        input  valid, rot_x, rot_y, rot_z, clipped,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/qvr_numer.sv
`default_nettype none

module qvr_numer
    import qvr_pkg::*;
#(
    parameter int QW = 16,
    parameter int VW = 16,
    localparam int NW = 2*QW + VW + 5,
    localparam int DW = 2*QW + 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [QW-1:0] quat_u [LANES],
    input  logic signed [QW-1:0] quat_w,
    input  logic signed [VW-1:0] vec_v [LANES],
    output qvr_ctl_t             ctl_out,
    output logic signed [NW-1:0] num_out [LANES],
    output logic        [DW-1:0] den_out
);

    localparam int PQ  = 2*QW;
    localparam int PV  = QW + VW;
    localparam int SW  = 2*QW + 3;
    localparam int DTW = QW + VW + 2;
    localparam int CW  = QW + VW + 1;
    localparam int TW  = 2*QW + VW + 3;

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: products
    logic signed [PQ-1:0] sq_reg [LANES];
    logic signed [PQ-1:0] ww_reg;
    logic signed [PV-1:0] uv_reg [LANES];
    logic signed [PV-1:0] cp_reg [LANES];
    logic signed [PV-1:0] cm_reg [LANES];
    logic signed [QW-1:0] u1_reg [LANES];
    logic signed [VW-1:0] v1d_reg [LANES];
    logic signed [QW-1:0] w1_reg;

    // stage 2: sums
    logic signed [SW-1:0]  s_reg;
    logic signed [DW:0]    den2_reg;
    logic signed [DTW-1:0] dot_reg;
    logic signed [CW-1:0]  c_reg [LANES];
    logic signed [QW-1:0]  u2_reg [LANES];
    logic signed [VW-1:0]  v2d_reg [LANES];
    logic signed [QW-1:0]  w2_reg;

    // stage 3: numerator terms
    logic signed [TW-1:0] ta_reg [LANES];
    logic signed [TW-1:0] tb_reg [LANES];
    logic signed [TW-1:0] tc_reg [LANES];
    logic signed [DW:0]   den3_reg;

    // stage 4: numerator
    logic signed [NW-1:0] n_reg [LANES];
    logic [DW-1:0]        den4_reg;
    logic                 zero4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg   <= PQ'(quat_w) * PQ'(quat_w);
            w1_reg   <= quat_w;
            s_reg    <= SW'(ww_reg) - SW'(sq_reg[0]) - SW'(sq_reg[1]) - SW'(sq_reg[2]);
            den2_reg <= (DW+1)'(ww_reg) + (DW+1)'(sq_reg[0]) + (DW+1)'(sq_reg[1])
                        + (DW+1)'(sq_reg[2]);
            dot_reg  <= DTW'(uv_reg[0]) + DTW'(uv_reg[1]) + DTW'(uv_reg[2]);
            w2_reg   <= w1_reg;
            den3_reg <= den2_reg;
            den4_reg <= DW'(den3_reg);
            zero4_reg <= (den3_reg == '0);
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        localparam int J1 = (g + 1) % 3;
        localparam int J2 = (g + 2) % 3;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[g]  <= PQ'(quat_u[g]) * PQ'(quat_u[g]);
                uv_reg[g]  <= PV'(quat_u[g]) * PV'(vec_v[g]);
                cp_reg[g]  <= PV'(quat_u[J1]) * PV'(vec_v[J2]);
                cm_reg[g]  <= PV'(quat_u[J2]) * PV'(vec_v[J1]);
                u1_reg[g]  <= quat_u[g];
                v1d_reg[g] <= vec_v[g];

                c_reg[g]   <= CW'(cp_reg[g]) - CW'(cm_reg[g]);
                u2_reg[g]  <= u1_reg[g];
                v2d_reg[g] <= v1d_reg[g];

                ta_reg[g]  <= TW'(s_reg) * TW'(v2d_reg[g]);
                tb_reg[g]  <= (TW'(dot_reg) * TW'(u2_reg[g])) <<< 1;
                tc_reg[g]  <= (TW'(w2_reg) * TW'(c_reg[g])) <<< 1;

                n_reg[g]   <= NW'(ta_reg[g]) + NW'(tb_reg[g]) + NW'(tc_reg[g]);
            end
        end

        assign num_out[g] = n_reg[g];
    end

    assign ctl_out.valid = v4_reg;
    assign ctl_out.zero  = zero4_reg;
    assign den_out       = den4_reg;

endmodule

`default_nettype wire

>>> rtl/qvr_divider.sv
`default_nettype none

module qvr_divider
    import qvr_pkg::*;
#(
    parameter int QW = 16,
    parameter int VW = 16,
    localparam int NW = 2*QW + VW + 5,
    localparam int DW = 2*QW + 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  qvr_ctl_t             ctl_in,
    input  logic signed [NW-1:0] num_in [LANES],
    input  logic        [DW-1:0] den_in,
    output logic                 out_valid,
    output logic signed [VW-1:0] rot [LANES],
    output logic                 clipped
);

    localparam int RW = NW;

    // magnitude stage
    qvr_ctl_t      ctl_p_reg;
    logic [RW-1:0] mag_p_reg [LANES];
    logic          neg_p_reg [LANES];
    logic [DW-1:0] den_p_reg;

    // overflow check (index 0), then one quotient bit per stage
    qvr_ctl_t      ctl_s_reg [VW+1];
    logic [DW-1:0] den_s_reg [VW+1];
    logic [RW-1:0] rem_s_reg [VW+1][LANES];
    logic [VW-1:0] q_s_reg   [VW+1][LANES];
    logic          neg_s_reg [VW+1][LANES];
    logic          ovf_s_reg [VW+1][LANES];

    logic [RW-1:0] rem_next [VW+1][LANES];
    logic [VW-1:0] q_next   [VW+1][LANES];
    logic          ovf_next [LANES];

    logic                 valid_reg;
    logic signed [VW-1:0] rot_reg [LANES];
    logic                 clip_reg;

    logic signed [VW-1:0] rot_next [LANES];
    logic                 clip_next;

    always_comb
    begin
        logic [RW-1:0] shd;
        logic          ge;
        for (int l = 0; l < LANES; l++)
        begin
            ovf_next[l]    = mag_p_reg[l] >= (RW'(den_p_reg) << VW);
            rem_next[0][l] = mag_p_reg[l];
            q_next[0][l]   = '0;
        end
        for (int k = 1; k <= VW; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                shd            = RW'(den_s_reg[k-1]) << (VW - k);
                ge             = rem_s_reg[k-1][l] >= shd;
                rem_next[k][l] = ge ? (rem_s_reg[k-1][l] - shd) : rem_s_reg[k-1][l];
                q_next[k][l]   = q_s_reg[k-1][l];
                q_next[k][l][VW-k] = ge;
            end
        end
    end

    always_comb
    begin
        logic [VW-1:0] q;
        logic          over;
        clip_next = 1'b0;
        for (int l = 0; l < LANES; l++)
        begin
            q = q_s_reg[VW][l];
            if (ctl_s_reg[VW].zero)
            begin
                over        = 1'b0;
                rot_next[l] = '0;
            end
            else if (!neg_s_reg[VW][l])
            begin
                over        = ovf_s_reg[VW][l] | q[VW-1];
                rot_next[l] = over ? {1'b0, {(VW-1){1'b1}}} : q;
            end
            else
            begin
                over        = ovf_s_reg[VW][l] | (q[VW-1] & (|q[VW-2:0]));
                rot_next[l] = over ? {1'b1, {(VW-1){1'b0}}} : (~q + VW'(1));
            end
            clip_next = clip_next | over;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_p_reg <= '0;
            for (int k = 0; k <= VW; k++)
            begin
                ctl_s_reg[k] <= '0;
            end
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ctl_p_reg    <= ctl_in;
            ctl_s_reg[0] <= ctl_p_reg;
            for (int k = 1; k <= VW; k++)
            begin
                ctl_s_reg[k] <= ctl_s_reg[k-1];
            end
            valid_reg <= ctl_s_reg[VW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_p_reg    <= den_in;
            den_s_reg[0] <= den_p_reg;
            for (int l = 0; l < LANES; l++)
            begin
                neg_p_reg[l]    <= num_in[l][NW-1];
                mag_p_reg[l]    <= num_in[l][NW-1] ? RW'(-num_in[l]) : RW'(num_in[l]);
                neg_s_reg[0][l] <= neg_p_reg[l];
                ovf_s_reg[0][l] <= ovf_next[l];
                rem_s_reg[0][l] <= rem_next[0][l];
                q_s_reg[0][l]   <= q_next[0][l];
                rot_reg[l]      <= rot_next[l];
            end
            for (int k = 1; k <= VW; k++)
            begin
                den_s_reg[k] <= den_s_reg[k-1];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_s_reg[k][l] <= rem_next[k][l];
                    q_s_reg[k][l]   <= q_next[k][l];
                    neg_s_reg[k][l] <= neg_s_reg[k-1][l];
                    ovf_s_reg[k][l] <= ovf_s_reg[k-1][l];
                end
            end
            clip_reg <= clip_next;
        end
    end

    assign out_valid = valid_reg;
    assign rot       = rot_reg;
    assign clipped   = clip_reg;

endmodule

`default_nettype wire

>>> rtl/quaternion_vector_rotate.sv
// Throughput: one word per cycle while the output is not stalled.
// The divider takes one quotient bit per stage.
// A stalled output freezes the whole pipeline; ready follows the output register.
// Reset clears all valid bits; data registers are not reset.
`default_nettype none

module quaternion_vector_rotate
    import qvr_pkg::*;
#(
    parameter int QUAT_WIDTH = 16,
    parameter int VEC_WIDTH  = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    qvr_in_if.sink    in_ch,
    qvr_out_if.source out_ch
);

    localparam int NW = 2*QUAT_WIDTH + VEC_WIDTH + 5;
    localparam int DW = 2*QUAT_WIDTH + 2;

    logic                         en;
    logic                         out_valid;
    logic signed [QUAT_WIDTH-1:0] quat_u [LANES];
    logic signed [VEC_WIDTH-1:0]  vec_v  [LANES];
    qvr_ctl_t                     num_ctl;
    logic signed [NW-1:0]         num    [LANES];
    logic        [DW-1:0]         den;
    logic signed [VEC_WIDTH-1:0]  rot    [LANES];
    logic                         clipped;

    assign en = !out_valid || out_ch.ready;
    assign in_ch.ready = en;

    assign quat_u[0] = in_ch.quat_x;
    assign quat_u[1] = in_ch.quat_y;
    assign quat_u[2] = in_ch.quat_z;
    assign vec_v[0]  = in_ch.vec_x;
    assign vec_v[1]  = in_ch.vec_y;
    assign vec_v[2]  = in_ch.vec_z;

    qvr_numer #(
        .QW (QUAT_WIDTH),
        .VW (VEC_WIDTH)
    ) u_numer (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_ch.valid),
        .quat_u   (quat_u),
        .quat_w   (in_ch.quat_w),
        .vec_v    (vec_v),
        .ctl_out  (num_ctl),
        .num_out  (num),
        .den_out  (den)
    );

    qvr_divider #(
        .QW (QUAT_WIDTH),
        .VW (VEC_WIDTH)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (num_ctl),
        .num_in    (num),
        .den_in    (den),
        .out_valid (out_valid),
        .rot       (rot),
        .clipped   (clipped)
    );

    assign out_ch.valid   = out_valid;
    assign out_ch.rot_x   = rot[0];
    assign out_ch.rot_y   = rot[1];
    assign out_ch.rot_z   = rot[2];
    assign out_ch.clipped = clipped;

endmodule

`default_nettype wire
